### sv/i420wb_pkg.sv
// Shared types and constants for the I420 2x2 block white-balance unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package i420wb_pkg;

    // Pixels in one 2x2 block, one lane each
    localparam int NUM_LANES   = 4;
    // Register stages inside one lane, and in the whole datapath
    localparam int LANE_STAGES = 5;
    localparam int PIPE_DEPTH  = LANE_STAGES + 1;

    localparam int GAIN_W = 12;
    localparam int BYTE_W = 8;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 12'd1000;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_RED_GAIN  = 1'b0,
        REG_BLUE_GAIN = 1'b1
    } i420wb_reg_idx_t;

    // BT.601 forward (YUV to RGB) coefficients
    localparam logic signed [19:0] K_Y  = 20'sd298;
    localparam logic signed [19:0] K_RV = 20'sd409;
    localparam logic signed [19:0] K_GU = 20'sd100;
    localparam logic signed [19:0] K_GV = 20'sd208;
    localparam logic signed [19:0] K_BU = 20'sd516;

    // BT.601 reverse (RGB to YUV) coefficients
    localparam logic [15:0] K_YR = 16'd66;
    localparam logic [15:0] K_YG = 16'd129;
    localparam logic [15:0] K_YB = 16'd25;
    localparam logic signed [16:0] K_UR = 17'sd38;
    localparam logic signed [16:0] K_UG = 17'sd74;
    localparam logic signed [16:0] K_UB = 17'sd112;
    localparam logic signed [16:0] K_VR = 17'sd112;
    localparam logic signed [16:0] K_VG = 17'sd94;
    localparam logic signed [16:0] K_VB = 17'sd18;

    // Permille scaling: divide by 1000 through a reciprocal of 1049 / 2^20
    localparam logic [20:0] PERMILLE     = 21'd1000;
    localparam logic [20:0] PERMILLE_RND = 21'd500;
    localparam logic [31:0] RECIP_MUL    = 32'd1049;
    localparam int          RECIP_SHIFT  = 20;

    // What one lane hands to the merging stage
    typedef struct packed {
        logic [BYTE_W-1:0] y;
        logic [BYTE_W-1:0] u;
        logic [BYTE_W-1:0] v;
    } i420wb_pix_t;

endpackage

### sv/i420wb_lane.sv
// One pixel lane: YUV to RGB, red/blue permille gain, RGB back to YUV terms.
// Depends on i420wb_pkg; five register stages, a new pixel every cycle.
`timescale 1ns / 1ps

module i420wb_lane (
    input  logic                               clk,
    input  logic [i420wb_pkg::BYTE_W-1:0]      luma,
    input  logic [i420wb_pkg::BYTE_W-1:0]      cb,
    input  logic [i420wb_pkg::BYTE_W-1:0]      cr,
    input  logic [i420wb_pkg::GAIN_W-1:0]      gain_red,
    input  logic [i420wb_pkg::GAIN_W-1:0]      gain_blue,
    output i420wb_pkg::i420wb_pix_t            pix
);
    import i420wb_pkg::*;

    // Floor shift by 8, then clip to a byte
    function automatic logic [7:0] sat_shift8(input logic signed [19:0] x);
        logic signed [11:0] s;
        s = x[19:8];
        if (s < 12'sd0)
            return 8'd0;
        else if (s > 12'sd255)
            return 8'd255;
        else
            return s[7:0];
    endfunction

    // Clip an 11-bit quotient to a byte
    function automatic logic [7:0] sat_u11(input logic [10:0] x);
        if (x > 11'd255)
            return 8'd255;
        else
            return x[7:0];
    endfunction

    // ---------------- stage 1: YUV to RGB ----------------
    logic [7:0]        c_val;
    logic signed [19:0] c_x, d_x, e_x;
    logic signed [19:0] r_pre, g_pre, b_pre;
    logic [7:0]        r1_reg, g1_reg, b1_reg;

    always_comb
    begin
        c_val = (luma >= 8'd16) ? (luma - 8'd16) : 8'd0;
        c_x   = 20'(c_val);
        d_x   = 20'(cb) - 20'sd128;
        e_x   = 20'(cr) - 20'sd128;
        r_pre = K_Y * c_x + K_RV * e_x + 20'sd128;
        g_pre = K_Y * c_x - K_GU * d_x - K_GV * e_x + 20'sd128;
        b_pre = K_Y * c_x + K_BU * d_x + 20'sd128;
    end

    always_ff @(posedge clk)
    begin
        r1_reg <= sat_shift8(r_pre);
        g1_reg <= sat_shift8(g_pre);
        b1_reg <= sat_shift8(b_pre);
    end

    // ---------------- stage 2: gain multiply with rounding term ----------------
    logic [20:0] pr2_reg, pb2_reg;
    logic [7:0]  g2_reg;

    always_ff @(posedge clk)
    begin
        pr2_reg <= 21'(r1_reg) * 21'(gain_red) + PERMILLE_RND;
        pb2_reg <= 21'(b1_reg) * 21'(gain_blue) + PERMILLE_RND;
        g2_reg  <= g1_reg;
    end

    // ---------------- stage 3: reciprocal estimate of p / 1000 ----------------
    logic [31:0] qr_prod, qb_prod;
    logic [10:0] qr3_reg, qb3_reg;
    logic [20:0] pr3_reg, pb3_reg;
    logic [7:0]  g3_reg;

    always_comb
    begin
        qr_prod = 32'(pr2_reg) * RECIP_MUL;
        qb_prod = 32'(pb2_reg) * RECIP_MUL;
    end

    always_ff @(posedge clk)
    begin
        qr3_reg <= qr_prod[RECIP_SHIFT +: 11];
        qb3_reg <= qb_prod[RECIP_SHIFT +: 11];
        pr3_reg <= pr2_reg;
        pb3_reg <= pb2_reg;
        g3_reg  <= g2_reg;
    end

    // ---------------- stage 4: correct estimate by one, clip ----------------
    // The estimate is exact or one too high
    logic [20:0] qr_back, qb_back;
    logic [10:0] qr_fix, qb_fix;
    logic [7:0]  r4_reg, g4_reg, b4_reg;

    always_comb
    begin
        qr_back = 21'(qr3_reg) * PERMILLE;
        qb_back = 21'(qb3_reg) * PERMILLE;
        qr_fix  = (qr_back > pr3_reg) ? (qr3_reg - 11'd1) : qr3_reg;
        qb_fix  = (qb_back > pb3_reg) ? (qb3_reg - 11'd1) : qb3_reg;
    end

    always_ff @(posedge clk)
    begin
        r4_reg <= sat_u11(qr_fix);
        b4_reg <= sat_u11(qb_fix);
        g4_reg <= g3_reg;
    end

    // ---------------- stage 5: RGB back to luma and chroma terms ----------------
    logic [15:0]        y_acc;
    logic [8:0]         y_sum;
    logic signed [16:0] r_x, g_x, b_x;
    logic signed [16:0] u_acc, v_acc;
    logic signed [9:0]  u_term, v_term;
    i420wb_pix_t        pix_reg;

    always_comb
    begin
        y_acc  = K_YR * 16'(r4_reg) + K_YG * 16'(g4_reg) + K_YB * 16'(b4_reg) + 16'd128;
        y_sum  = 9'(y_acc[15:8]) + 9'd16;
        r_x    = 17'(r4_reg);
        g_x    = 17'(g4_reg);
        b_x    = 17'(b4_reg);
        u_acc  = K_UB * b_x - K_UR * r_x - K_UG * g_x + 17'sd128;
        v_acc  = K_VR * r_x - K_VG * g_x - K_VB * b_x + 17'sd128;
        u_term = 10'($signed(u_acc[16:8])) + 10'sd128;
        v_term = 10'($signed(v_acc[16:8])) + 10'sd128;
    end

    always_ff @(posedge clk)
    begin
        pix_reg.y <= (y_sum > 9'd255) ? 8'd255 : y_sum[7:0];
        pix_reg.u <= u_term[7:0];
        pix_reg.v <= v_term[7:0];
    end

    assign pix = pix_reg;

endmodule

### sv/i420wb_merge.sv
// Merging stage: pass the four lumas and average the four chroma terms.
// Depends on i420wb_pkg; one register stage.
`timescale 1ns / 1ps

module i420wb_merge (
    input  logic                                 clk,
    input  i420wb_pkg::i420wb_pix_t              lane_pix [i420wb_pkg::NUM_LANES],
    output logic [i420wb_pkg::BYTE_W-1:0]        luma_out [i420wb_pkg::NUM_LANES],
    output logic [i420wb_pkg::BYTE_W-1:0]        cb_avg,
    output logic [i420wb_pkg::BYTE_W-1:0]        cr_avg
);
    import i420wb_pkg::*;

    localparam int SUM_W = BYTE_W + $clog2(NUM_LANES) + 1;

    logic [SUM_W-1:0]  u_sum, v_sum;
    logic [BYTE_W-1:0] luma_reg [NUM_LANES];
    logic [BYTE_W-1:0] cb_reg, cr_reg;

    // Sum chroma terms with the rounding half
    always_comb
    begin
        u_sum = SUM_W'(NUM_LANES / 2);
        v_sum = SUM_W'(NUM_LANES / 2);
        for (int i = 0; i < NUM_LANES; i++)
        begin
            u_sum = u_sum + SUM_W'(lane_pix[i].u);
            v_sum = v_sum + SUM_W'(lane_pix[i].v);
        end
    end

    // Register the finished block
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM_LANES; i++)
            luma_reg[i] <= lane_pix[i].y;
        cb_reg <= u_sum[$clog2(NUM_LANES) +: BYTE_W];
        cr_reg <= v_sum[$clog2(NUM_LANES) +: BYTE_W];
    end

    assign luma_out = luma_reg;
    assign cb_avg   = cb_reg;
    assign cr_avg   = cr_reg;

endmodule

### sv/i420_block_white_balance_unit.sv
// Top level of the I420 2x2 block white-balance unit.
// Depends on i420wb_pkg, i420wb_lane and i420wb_merge.
`timescale 1ns / 1ps

// One 2x2 block (four lumas, shared U and V) enters per cycle; busy never
// rises, so start may be held high every cycle. Each block goes through four
// pixel lanes of five register stages and a one-stage chroma merge, and its
// result appears on the output ports, with done high for a single cycle, once
// it leaves the merge register. The receiver cannot stall: capture every
// result on the cycle done is high. Gain registers are written through
// cfg_we / cfg_index / cfg_data and should change only when no block is in
// flight.
module i420_block_white_balance_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [0:0]                       cfg_index,
    input  logic [i420wb_pkg::GAIN_W-1:0]    cfg_data,
    input  logic                             start,
    output logic                             busy,
    input  logic [i420wb_pkg::BYTE_W-1:0]    luma_in_top_left,
    input  logic [i420wb_pkg::BYTE_W-1:0]    luma_in_top_right,
    input  logic [i420wb_pkg::BYTE_W-1:0]    luma_in_bottom_left,
    input  logic [i420wb_pkg::BYTE_W-1:0]    luma_in_bottom_right,
    input  logic [i420wb_pkg::BYTE_W-1:0]    cb_in,
    input  logic [i420wb_pkg::BYTE_W-1:0]    cr_in,
    output logic                             done,
    output logic [i420wb_pkg::BYTE_W-1:0]    luma_out_top_left,
    output logic [i420wb_pkg::BYTE_W-1:0]    luma_out_top_right,
    output logic [i420wb_pkg::BYTE_W-1:0]    luma_out_bottom_left,
    output logic [i420wb_pkg::BYTE_W-1:0]    luma_out_bottom_right,
    output logic [i420wb_pkg::BYTE_W-1:0]    cb_out,
    output logic [i420wb_pkg::BYTE_W-1:0]    cr_out
);
    import i420wb_pkg::*;

    logic [GAIN_W-1:0]     gain_red_reg, gain_blue_reg;
    logic [PIPE_DEPTH-1:0] valid_reg;
    logic                  accept;
    logic [BYTE_W-1:0]     luma_lane [NUM_LANES];
    i420wb_pix_t           lane_pix  [NUM_LANES];
    logic [BYTE_W-1:0]     luma_res  [NUM_LANES];

    // Every cycle is open for a new block
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Write gain registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_red_reg  <= GAIN_RESET;
            gain_blue_reg <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (i420wb_reg_idx_t'(cfg_index))
                REG_RED_GAIN:  gain_red_reg  <= cfg_data;
                REG_BLUE_GAIN: gain_blue_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Advance the transaction valid flags alongside the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], accept};
    end

    assign done = valid_reg[PIPE_DEPTH-1];

    assign luma_lane[0] = luma_in_top_left;
    assign luma_lane[1] = luma_in_top_right;
    assign luma_lane[2] = luma_in_bottom_left;
    assign luma_lane[3] = luma_in_bottom_right;

    // One lane per pixel of the block
    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        i420wb_lane u_lane (
            .clk       (clk),
            .luma      (luma_lane[i]),
            .cb        (cb_in),
            .cr        (cr_in),
            .gain_red  (gain_red_reg),
            .gain_blue (gain_blue_reg),
            .pix       (lane_pix[i])
        );
    end

    // Combine the lanes
    i420wb_merge u_merge (
        .clk      (clk),
        .lane_pix (lane_pix),
        .luma_out (luma_res),
        .cb_avg   (cb_out),
        .cr_avg   (cr_out)
    );

    assign luma_out_top_left     = luma_res[0];
    assign luma_out_top_right    = luma_res[1];
    assign luma_out_bottom_left  = luma_res[2];
    assign luma_out_bottom_right = luma_res[3];

    // Every accepted block is delivered after the fixed latency
    a_start_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##6 done)
        else $error("accepted block not delivered after pipeline latency");

    // No result without a block accepted at the matching earlier edge
    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> valid_reg[PIPE_DEPTH-2:0] == $past(valid_reg[PIPE_DEPTH-2:0]) ||
                 $past(valid_reg[PIPE_DEPTH-2])) 
        else $error("result strobe without a block in flight");

    // Gains only change on a configuration write
    a_gain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> $stable(gain_red_reg) && $stable(gain_blue_reg))
        else $error("gain register changed without a write");

    // Averaged chroma stays in the BT.601 range
    a_chroma_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> cb_out <= 8'd240 && cr_out <= 8'd240 && cb_out >= 8'd16 && cr_out >= 8'd16)
        else $error("averaged chroma outside 16..240");

endmodule

### verif/tb_i420_block_white_balance_unit.sv
// Testbench for the I420 2x2 block white-balance unit: directed and random blocks
// checked against a built-in predictor. Depends on i420wb_pkg and the top level.
`timescale 1ns / 1ps

module tb_i420_block_white_balance_unit;

    import i420wb_pkg::*;

    // One 2x2 block: luma[0..3] is top-left, top-right, bottom-left, bottom-right
    typedef struct packed {
        logic [NUM_LANES-1:0][BYTE_W-1:0] luma;
        logic [BYTE_W-1:0]                cb;
        logic [BYTE_W-1:0]                cr;
    } wb_block_t;

    // Tracks the gains, predicts each block and checks what comes out
    class wb_scoreboard;
        wb_block_t         balanced_q[$];
        logic [GAIN_W-1:0] gain_red;
        logic [GAIN_W-1:0] gain_blue;
        int                mismatches;

        function new();
            gain_red   = GAIN_RESET;
            gain_blue  = GAIN_RESET;
            mismatches = 0;
        endfunction

        function void set_gain(i420wb_reg_idx_t idx, logic [GAIN_W-1:0] val);
            if (idx == REG_RED_GAIN)
                gain_red = val;
            else
                gain_blue = val;
        endfunction

        function int pending();
            return balanced_q.size();
        endfunction

        function int sat_to_byte(int x);
            if (x < 0)
                return 0;
            if (x > 255)
                return 255;
            return x;
        endfunction

        // Permille gain with rounding, saturated to a byte
        function int scale_channel(int ch, logic [GAIN_W-1:0] gain);
            int prod;
            prod = ch * int'(gain) + 500;
            return sat_to_byte(prod / 1000);
        endfunction

        function wb_block_t balance_block(wb_block_t blk);
            wb_block_t res;
            int        d;
            int        e;
            int        c;
            int        r;
            int        g;
            int        b;
            int        u_sum;
            int        v_sum;
            d     = int'(blk.cb) - 128;
            e     = int'(blk.cr) - 128;
            u_sum = 0;
            v_sum = 0;
            for (int k = 0; k < NUM_LANES; k++)
            begin
                c = int'(blk.luma[k]) - 16;
                if (c < 0)
                    c = 0;
                // Forward to RGB, floor shifts on signed values
                r = sat_to_byte((298 * c + 409 * e + 128) >>> 8);
                g = sat_to_byte((298 * c - 100 * d - 208 * e + 128) >>> 8);
                b = sat_to_byte((298 * c + 516 * d + 128) >>> 8);
                r = scale_channel(r, gain_red);
                b = scale_channel(b, gain_blue);
                // Back to YUV; chroma accumulates over the block
                res.luma[k] = BYTE_W'(sat_to_byte(((66 * r + 129 * g + 25 * b + 128) >>> 8)
                                                  + 16));
                u_sum += ((-38 * r - 74 * g + 112 * b + 128) >>> 8) + 128;
                v_sum += ((112 * r - 94 * g - 18 * b + 128) >>> 8) + 128;
            end
            res.cb = (u_sum + 2 < 0) ? 8'd0 : BYTE_W'(sat_to_byte((u_sum + 2) / 4));
            res.cr = (v_sum + 2 < 0) ? 8'd0 : BYTE_W'(sat_to_byte((v_sum + 2) / 4));
            return res;
        endfunction

        function void note_block(wb_block_t blk);
            balanced_q.push_back(balance_block(blk));
        endfunction

        function void compare_field(string field, logic [BYTE_W-1:0] want,
                                    logic [BYTE_W-1:0] got);
            if (want !== got)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: mismatch on %s: expected %0d, got %0d",
                             $realtime, field, want, got);
            end
        endfunction

        function void check_block(wb_block_t got);
            wb_block_t want;
            if (balanced_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no block in flight: %h", $realtime, got);
                return;
            end
            want = balanced_q.pop_front();
            compare_field("luma_out_top_left", want.luma[0], got.luma[0]);
            compare_field("luma_out_top_right", want.luma[1], got.luma[1]);
            compare_field("luma_out_bottom_left", want.luma[2], got.luma[2]);
            compare_field("luma_out_bottom_right", want.luma[3], got.luma[3]);
            compare_field("cb_out", want.cb, got.cb);
            compare_field("cr_out", want.cr, got.cr);
        endfunction
    endclass

    localparam int ITEMS_PER_PHASE = 70;
    localparam int NUM_PHASES      = 8;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [0:0]                cfg_index;
    logic [GAIN_W-1:0]         cfg_data;
    logic                      start;
    logic                      busy;
    logic                      done;
    wb_block_t                 blk_in;
    logic [BYTE_W-1:0]         y_out_tl;
    logic [BYTE_W-1:0]         y_out_tr;
    logic [BYTE_W-1:0]         y_out_bl;
    logic [BYTE_W-1:0]         y_out_br;
    logic [BYTE_W-1:0]         cb_res;
    logic [BYTE_W-1:0]         cr_res;

    wb_scoreboard sb;

    i420_block_white_balance_unit u_top (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .start                 (start),
        .busy                  (busy),
        .luma_in_top_left      (blk_in.luma[0]),
        .luma_in_top_right     (blk_in.luma[1]),
        .luma_in_bottom_left   (blk_in.luma[2]),
        .luma_in_bottom_right  (blk_in.luma[3]),
        .cb_in                 (blk_in.cb),
        .cr_in                 (blk_in.cr),
        .done                  (done),
        .luma_out_top_left     (y_out_tl),
        .luma_out_top_right    (y_out_tr),
        .luma_out_bottom_left  (y_out_bl),
        .luma_out_bottom_right (y_out_br),
        .cb_out                (cb_res),
        .cr_out                (cr_res)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Note each accepted transaction and check each result on the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_block(blk_in);
            if (done)
                sb.check_block({y_out_br, y_out_bl, y_out_tr, y_out_tl, cb_res, cr_res});
        end
    end

    // Random byte, leaning on the clamp and clip corners a quarter of the time
    function automatic logic [BYTE_W-1:0] pick_byte();
        logic [BYTE_W-1:0] corners [7];
        corners = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd17, 8'd254, 8'd255};
        if ($urandom_range(3) == 0)
            return corners[$urandom_range(6)];
        return BYTE_W'($urandom_range(255));
    endfunction

    function automatic wb_block_t random_block();
        wb_block_t blk;
        for (int k = 0; k < NUM_LANES; k++)
            blk.luma[k] = pick_byte();
        blk.cb = pick_byte();
        blk.cr = pick_byte();
        return blk;
    endfunction

    // Entered and left at a falling edge; start stays high after the transaction
    task automatic send_block(input wb_block_t blk, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start  <= 1'b1;
        blk_in <= blk;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Drop start and hold until every block in flight has come out
    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    // Write both gains on consecutive cycles, block idle
    task automatic write_gains(input logic [GAIN_W-1:0] red, input logic [GAIN_W-1:0] blue);
        cfg_we    <= 1'b1;
        cfg_index <= REG_RED_GAIN;
        cfg_data  <= red;
        sb.set_gain(REG_RED_GAIN, red);
        @(negedge clk);
        cfg_index <= REG_BLUE_GAIN;
        cfg_data  <= blue;
        sb.set_gain(REG_BLUE_GAIN, blue);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        wb_block_t         directed [$];
        wb_block_t         blk;
        int                idle_pattern [3];
        logic [GAIN_W-1:0] red;
        logic [GAIN_W-1:0] blue;

        sb           = new();
        idle_pattern = '{0, 63, 26};
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = REG_RED_GAIN;
        cfg_data     = '0;
        start        = 1'b0;
        blk_in       = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed blocks at reset gains: field extremes, black clamp, chroma corners
        directed.push_back('{luma: '0, cb: 8'd0, cr: 8'd0});
        directed.push_back('{luma: '1, cb: 8'd255, cr: 8'd255});
        directed.push_back('{luma: '0, cb: 8'd128, cr: 8'd128});
        directed.push_back('{luma: '1, cb: 8'd128, cr: 8'd128});
        directed.push_back('{luma: {8'd15, 8'd16, 8'd17, 8'd0}, cb: 8'd128, cr: 8'd128});
        directed.push_back('{luma: {8'd235, 8'd235, 8'd235, 8'd235}, cb: 8'd0, cr: 8'd255});
        directed.push_back('{luma: {8'd16, 8'd16, 8'd16, 8'd16}, cb: 8'd255, cr: 8'd0});
        directed.push_back('{luma: '0, cb: 8'd255, cr: 8'd0});
        directed.push_back('{luma: '0, cb: 8'd0, cr: 8'd255});
        directed.push_back('{luma: '1, cb: 8'd0, cr: 8'd0});
        directed.push_back('{luma: '1, cb: 8'd255, cr: 8'd0});
        directed.push_back('{luma: {8'd255, 8'd0, 8'd255, 8'd0}, cb: 8'd0, cr: 8'd255});
        directed.push_back('{luma: {8'd0, 8'd255, 8'd0, 8'd255}, cb: 8'd127, cr: 8'd129});
        directed.push_back('{luma: {8'h55, 8'haa, 8'h0f, 8'hf0}, cb: 8'h55, cr: 8'haa});
        directed.push_back('{luma: {8'd126, 8'd127, 8'd128, 8'd129}, cb: 8'd1, cr: 8'd254});
        foreach (directed[i])
            send_block(directed[i], 0);
        wait_drained();

        // Random phases, each under its own gains and idling
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       begin red = 12'd0;    blue = 12'd0;    end
                1:       begin red = 12'd4095; blue = 12'd4095; end
                2:       begin red = 12'd400;  blue = 12'd2300; end
                3:       begin red = 12'd2100; blue = 12'd200;  end
                4:       begin red = 12'd0;    blue = 12'd4095; end
                5:
                begin
                    red  = GAIN_W'($urandom_range(4095));
                    blue = GAIN_W'($urandom_range(4095));
                end
                default:
                begin
                    red  = GAIN_W'($urandom_range(2100, 400));
                    blue = GAIN_W'($urandom_range(2300, 200));
                end
            endcase
            write_gains(red, blue);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                blk = random_block();
                send_block(blk, idle_pattern[p % 3]);
            end
            wait_drained();
        end

        // Let any stray result surface before the verdict
        repeat (PIPE_DEPTH + 4) @(posedge clk);
        if (sb.pending() != 0)
            $display("%0d results never arrived", sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Watchdog: report errors and stop if the test has not finished first
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
